FILE: rtl/gfp_pkg.sv
// ---------------------------------------------------------------------------
// gfp_pkg
// Types and constants for the binary GNSS frame parser: transaction
// payloads, result kinds and the fixed sync and length values.
// ---------------------------------------------------------------------------
package gfp_pkg;

  localparam logic [7:0]  SYNC_ONE        = 8'hB5;
  localparam logic [7:0]  SYNC_TWO        = 8'h62;
  localparam logic [15:0] DEFAULT_MAX_LEN = 16'd4096;

  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_GOOD     = 2'd1;
  localparam logic [1:0] KIND_TOO_LONG = 2'd2;
  localparam logic [1:0] KIND_CK_FAIL  = 2'd3;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
  } gfp_in_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [15:0] out_index;
    logic [7:0]  frame_class;
    logic [7:0]  msg_id;
    logic [15:0] frame_length;
    logic [7:0]  frame_ck_a;
    logic [7:0]  frame_ck_b;
    logic [31:0] good_frames;
    logic [31:0] bad_frames;
  } gfp_out_t;

endpackage

FILE: rtl/gnss_binary_frame_parser.sv
// ---------------------------------------------------------------------------
// gnss_binary_frame_parser
// Byte-serial sync/header/payload parser with a running Fletcher-8 check,
// a length ceiling and saturating good/discarded frame counters.
// ---------------------------------------------------------------------------
//  channel   | ports                      | moves
//  ----------+----------------------------+----------------------------------
//  input     | in_valid, in_stall, in_data | one stream byte or clear request
//  result    | out_valid, out_stall,       | payload byte or frame verdict
//            | out_data                    |
//  config    | cfg_wr_en, cfg_wr_data      | payload length ceiling
//
//  one byte per cycle while in_stall is low; parser state updates in the cycle a
//  byte is accepted and its result appears in the output register on the next cycle
//  in_stall follows out_stall only while the output register holds a result
//  reset (rst_n, synchronous) returns to sync hunt, clears both counters and
//  sets the ceiling to 4096
// ---------------------------------------------------------------------------
module gnss_binary_frame_parser #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  gfp_pkg::gfp_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output gfp_pkg::gfp_out_t out_data,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data
);
  import gfp_pkg::*;

  localparam logic [3:0] PH_SYNC1   = 4'd0;
  localparam logic [3:0] PH_SYNC2   = 4'd1;
  localparam logic [3:0] PH_CLASS   = 4'd2;
  localparam logic [3:0] PH_ID      = 4'd3;
  localparam logic [3:0] PH_LENLO   = 4'd4;
  localparam logic [3:0] PH_LENHI   = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CKA     = 4'd7;
  localparam logic [3:0] PH_CKB     = 4'd8;

  logic [15:0] max_len_r;
  logic [3:0]  phase_r, phase_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [15:0] decl_len_r, decl_len_nxt;
  logic [15:0] taken_r, taken_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  ck_a_r, ck_a_nxt;
  logic [COUNT_WIDTH-1:0] good_r, good_nxt;
  logic [COUNT_WIDTH-1:0] bad_r, bad_nxt;
  logic        out_valid_r, out_valid_nxt;
  gfp_out_t    out_data_r, out_data_nxt;

  logic        in_acc;
  logic        emit;
  logic [1:0]  kind;
  logic [7:0]  res_byte;
  logic [15:0] res_index;
  logic [7:0]  res_ck_a;
  logic [7:0]  res_ck_b;
  logic [7:0]  b;
  logic [7:0]  add_a;
  logic [15:0] new_len;
  logic [15:0] taken_inc;
  logic [31:0] good_clip;
  logic [31:0] bad_clip;

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign b         = in_data.in_byte;
  assign new_len   = {b, len_lo_r};
  assign taken_inc = taken_r + 16'd1;

  // counters read back at 32 bits, clipped when wider
  generate
    if (COUNT_WIDTH > 32) begin : g_clip
      assign good_clip = (|good_nxt[COUNT_WIDTH-1:32]) ? '1 : good_nxt[31:0];
      assign bad_clip  = (|bad_nxt[COUNT_WIDTH-1:32]) ? '1 : bad_nxt[31:0];
    end else if (COUNT_WIDTH == 32) begin : g_same
      assign good_clip = good_nxt;
      assign bad_clip  = bad_nxt;
    end else begin : g_ext
      assign good_clip = {{(32-COUNT_WIDTH){1'b0}}, good_nxt};
      assign bad_clip  = {{(32-COUNT_WIDTH){1'b0}}, bad_nxt};
    end
  endgenerate

  always_comb begin
    phase_nxt    = phase_r;
    class_nxt    = class_r;
    id_nxt       = id_r;
    len_lo_nxt   = len_lo_r;
    decl_len_nxt = decl_len_r;
    taken_nxt    = taken_r;
    sum_a_nxt    = sum_a_r;
    sum_b_nxt    = sum_b_r;
    ck_a_nxt     = ck_a_r;
    good_nxt     = good_r;
    bad_nxt      = bad_r;
    emit         = 1'b0;
    kind         = KIND_PAYLOAD;
    res_byte     = 8'd0;
    res_index    = 16'd0;
    res_ck_a     = 8'd0;
    res_ck_b     = 8'd0;
    add_a        = sum_a_r + b;

    if (in_data.req_type == REQ_CLEAR) begin
      phase_nxt    = PH_SYNC1;
      class_nxt    = 8'd0;
      id_nxt       = 8'd0;
      len_lo_nxt   = 8'd0;
      decl_len_nxt = 16'd0;
      taken_nxt    = 16'd0;
      sum_a_nxt    = 8'd0;
      sum_b_nxt    = 8'd0;
      ck_a_nxt     = 8'd0;
      good_nxt     = '0;
      bad_nxt      = '0;
    end else begin
      case (phase_r)
        PH_SYNC2: begin
          if (b == SYNC_TWO) begin
            phase_nxt = PH_CLASS;
          end else if (b != SYNC_ONE) begin
            phase_nxt = PH_SYNC1;
          end
        end
        PH_CLASS: begin
          // checksum restarts at the class byte
          class_nxt = b;
          sum_a_nxt = b;
          sum_b_nxt = b;
          phase_nxt = PH_ID;
        end
        PH_ID: begin
          id_nxt    = b;
          sum_a_nxt = add_a;
          sum_b_nxt = sum_b_r + add_a;
          phase_nxt = PH_LENLO;
        end
        PH_LENLO: begin
          len_lo_nxt = b;
          sum_a_nxt  = add_a;
          sum_b_nxt  = sum_b_r + add_a;
          phase_nxt  = PH_LENHI;
        end
        PH_LENHI: begin
          sum_a_nxt    = add_a;
          sum_b_nxt    = sum_b_r + add_a;
          decl_len_nxt = new_len;
          taken_nxt    = 16'd0;
          if (new_len > max_len_r) begin
            bad_nxt   = (bad_r == '1) ? bad_r : bad_r + 1'b1;
            emit      = 1'b1;
            kind      = KIND_TOO_LONG;
            phase_nxt = PH_SYNC1;
          end else if (new_len == 16'd0) begin
            phase_nxt = PH_CKA;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum_a_nxt = add_a;
          sum_b_nxt = sum_b_r + add_a;
          taken_nxt = taken_inc;
          if (taken_inc == decl_len_r) begin
            phase_nxt = PH_CKA;
          end
          emit      = 1'b1;
          kind      = KIND_PAYLOAD;
          res_byte  = b;
          res_index = taken_r;
        end
        PH_CKA: begin
          ck_a_nxt  = b;
          phase_nxt = PH_CKB;
        end
        PH_CKB: begin
          emit      = 1'b1;
          res_ck_a  = ck_a_r;
          res_ck_b  = b;
          phase_nxt = PH_SYNC1;
          if (ck_a_r == sum_a_r && b == sum_b_r) begin
            kind     = KIND_GOOD;
            good_nxt = (good_r == '1) ? good_r : good_r + 1'b1;
          end else begin
            kind    = KIND_CK_FAIL;
            bad_nxt = (bad_r == '1) ? bad_r : bad_r + 1'b1;
          end
        end
        default: begin
          // sync hunt, also covers unused phase codes
          phase_nxt = (b == SYNC_ONE) ? PH_SYNC2 : PH_SYNC1;
        end
      endcase
    end

    out_data_nxt.out_kind     = kind;
    out_data_nxt.out_byte     = res_byte;
    out_data_nxt.out_index    = res_index;
    out_data_nxt.frame_class  = class_nxt;
    out_data_nxt.msg_id       = id_nxt;
    out_data_nxt.frame_length = decl_len_nxt;
    out_data_nxt.frame_ck_a   = res_ck_a;
    out_data_nxt.frame_ck_b   = res_ck_b;
    out_data_nxt.good_frames  = good_clip;
    out_data_nxt.bad_frames   = bad_clip;

    if (in_acc) begin
      out_valid_nxt = emit;
    end else begin
      out_valid_nxt = out_valid_r & out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= DEFAULT_MAX_LEN;
      phase_r     <= PH_SYNC1;
      class_r     <= 8'd0;
      id_r        <= 8'd0;
      len_lo_r    <= 8'd0;
      decl_len_r  <= 16'd0;
      taken_r     <= 16'd0;
      sum_a_r     <= 8'd0;
      sum_b_r     <= 8'd0;
      ck_a_r      <= 8'd0;
      good_r      <= '0;
      bad_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_len_r <= (cfg_wr_data == 16'd0) ? 16'd1 : cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        phase_r    <= phase_nxt;
        class_r    <= class_nxt;
        id_r       <= id_nxt;
        len_lo_r   <= len_lo_nxt;
        decl_len_r <= decl_len_nxt;
        taken_r    <= taken_nxt;
        sum_a_r    <= sum_a_nxt;
        sum_b_r    <= sum_b_nxt;
        ck_a_r     <= ck_a_nxt;
        good_r     <= good_nxt;
        bad_r      <= bad_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.req_type == REQ_CLEAR |=>
      phase_r == PH_SYNC1 && good_r == '0 && bad_r == '0)
    else $error("clear request did not reset parser");

  a_payload_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> taken_r < decl_len_r)
    else $error("payload index reached declared length");

  a_ceiling_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    max_len_r != 16'd0)
    else $error("length ceiling is zero");

  a_verdict_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.out_kind != KIND_PAYLOAD |->
      out_data_r.out_byte == 8'd0 && out_data_r.out_index == 16'd0)
    else $error("verdict carries payload fields");

  a_index_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.out_kind == KIND_PAYLOAD |->
      out_data_r.out_index < out_data_r.frame_length)
    else $error("payload index beyond frame length");

endmodule

FILE: tb/gfp_frame_checker.sv
// ---------------------------------------------------------------------------
// gfp_frame_checker
// Watches both channels and the ceiling register of the frame parser. It
// parses every accepted input transaction itself and compares each accepted
// result transaction, field by field, with the oldest awaited one.
// ---------------------------------------------------------------------------
module gfp_frame_checker #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  gfp_pkg::gfp_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  gfp_pkg::gfp_out_t out_data,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  output int                fail_count,
  output int                pending
);

  import gfp_pkg::*;

  typedef enum logic [3:0] {
    HUNT_SYNC1, HUNT_SYNC2, TAKE_CLASS, TAKE_ID, TAKE_LEN_LO, TAKE_LEN_HI,
    TAKE_PAYLOAD, TAKE_CK_A, TAKE_CK_B
  } parse_phase_t;

  localparam longint unsigned COUNT_CEIL = (COUNT_WIDTH >= 64) ?
    64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << COUNT_WIDTH) - 64'd1);

  parse_phase_t    phase;
  logic [7:0]      cls_seen;
  logic [7:0]      id_seen;
  logic [7:0]      len_lo_seen;
  logic [15:0]     declared_len;
  logic [15:0]     bytes_seen;
  logic [7:0]      run_a;
  logic [7:0]      run_b;
  logic [7:0]      rx_ck_a;
  longint unsigned good_total;
  longint unsigned bad_total;
  logic [15:0]     len_ceiling;
  int              mismatches;
  gfp_out_t        awaited_results[$];

  function automatic longint unsigned bump(input longint unsigned v);
    return (v >= COUNT_CEIL) ? COUNT_CEIL : v + 64'd1;
  endfunction

  function automatic logic [31:0] clip(input longint unsigned v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  task automatic clear_parse();
    phase        = HUNT_SYNC1;
    cls_seen     = '0;
    id_seen      = '0;
    len_lo_seen  = '0;
    declared_len = '0;
    bytes_seen   = '0;
    run_a        = '0;
    run_b        = '0;
    rx_ck_a      = '0;
  endtask

  task automatic fold(input logic [7:0] b);
    run_a = run_a + b;
    run_b = run_b + run_a;
  endtask

  task automatic emit(input logic [1:0] kind, input logic [7:0] b, input logic [15:0] idx,
                      input logic [7:0] ca, input logic [7:0] cb);
    gfp_out_t res;
    res.out_kind     = kind;
    res.out_byte     = b;
    res.out_index    = idx;
    res.frame_class  = cls_seen;
    res.msg_id       = id_seen;
    res.frame_length = declared_len;
    res.frame_ck_a   = ca;
    res.frame_ck_b   = cb;
    res.good_frames  = clip(good_total);
    res.bad_frames   = clip(bad_total);
    awaited_results.insert(awaited_results.size(), res);
  endtask

  // one accepted input transaction through the parser
  task automatic parse_byte(input gfp_in_t item);
    logic [7:0]  b;
    logic [15:0] idx;
    bit          ok;
    b = item.in_byte;
    if (item.req_type == REQ_CLEAR) begin
      clear_parse();
      good_total = 0;
      bad_total  = 0;
      return;
    end
    case (phase)
      HUNT_SYNC2: begin
        if (b == SYNC_TWO) phase = TAKE_CLASS;
        else if (b != SYNC_ONE) phase = HUNT_SYNC1;
      end
      TAKE_CLASS: begin
        cls_seen = b;
        run_a = '0;
        run_b = '0;
        fold(b);
        phase = TAKE_ID;
      end
      TAKE_ID: begin
        id_seen = b;
        fold(b);
        phase = TAKE_LEN_LO;
      end
      TAKE_LEN_LO: begin
        len_lo_seen = b;
        fold(b);
        phase = TAKE_LEN_HI;
      end
      TAKE_LEN_HI: begin
        fold(b);
        declared_len = {b, len_lo_seen};
        bytes_seen = '0;
        if (declared_len > len_ceiling) begin
          bad_total = bump(bad_total);
          emit(KIND_TOO_LONG, 8'd0, 16'd0, 8'd0, 8'd0);
          phase = HUNT_SYNC1;
        end else begin
          phase = (declared_len == 16'd0) ? TAKE_CK_A : TAKE_PAYLOAD;
        end
      end
      TAKE_PAYLOAD: begin
        idx = bytes_seen;
        fold(b);
        bytes_seen = bytes_seen + 16'd1;
        if (bytes_seen == declared_len) phase = TAKE_CK_A;
        emit(KIND_PAYLOAD, b, idx, 8'd0, 8'd0);
      end
      TAKE_CK_A: begin
        rx_ck_a = b;
        phase = TAKE_CK_B;
      end
      TAKE_CK_B: begin
        ok = (rx_ck_a == run_a) && (b == run_b);
        if (ok) good_total = bump(good_total);
        else bad_total = bump(bad_total);
        emit(ok ? KIND_GOOD : KIND_CK_FAIL, 8'd0, 16'd0, rx_ck_a, b);
        phase = HUNT_SYNC1;
      end
      default: begin
        phase = (b == SYNC_ONE) ? HUNT_SYNC2 : HUNT_SYNC1;
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    gfp_out_t want;
    if (!rst_n) begin
      clear_parse();
      good_total  = 0;
      bad_total   = 0;
      len_ceiling = DEFAULT_MAX_LEN;
      awaited_results.delete();
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result transaction with nothing awaited: %h", out_data);
        end else begin
          want = awaited_results.pop_front();
          check_field("out_kind", 32'(want.out_kind), 32'(out_data.out_kind));
          check_field("out_byte", 32'(want.out_byte), 32'(out_data.out_byte));
          check_field("out_index", 32'(want.out_index), 32'(out_data.out_index));
          check_field("frame_class", 32'(want.frame_class),
                      32'(out_data.frame_class));
          check_field("msg_id", 32'(want.msg_id), 32'(out_data.msg_id));
          check_field("frame_length", 32'(want.frame_length),
                      32'(out_data.frame_length));
          check_field("frame_ck_a", 32'(want.frame_ck_a), 32'(out_data.frame_ck_a));
          check_field("frame_ck_b", 32'(want.frame_ck_b), 32'(out_data.frame_ck_b));
          check_field("good_frames", want.good_frames, out_data.good_frames);
          check_field("bad_frames", want.bad_frames, out_data.bad_frames);
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) parse_byte(in_data);
      if (cfg_wr_en === 1'b1) len_ceiling = (cfg_wr_data == 16'd0) ? 16'd1 : cfg_wr_data;
    end
    pending    <= awaited_results.size();
    fail_count <= mismatches;
  end

endmodule

FILE: tb/gnss_binary_frame_parser_tb.sv
// ---------------------------------------------------------------------------
// gnss_binary_frame_parser_tb
// Feeds the frame parser with directed frames and then with random frames,
// noise, clears and broken frames under several length ceilings and idle
// mixes. A separate checker predicts and compares; this top gives the verdict.
// ---------------------------------------------------------------------------
module gnss_binary_frame_parser_tb;

  import gfp_pkg::*;

  localparam int ITEMS_PER_PHASE = 157;
  localparam int HOLD_CYCLES     = 80;
  localparam int WATCHDOG_LIMIT  = 2000;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  gfp_in_t     in_data     = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  gfp_out_t    out_data;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  int          fail_count;
  int          pending;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  bit          hold_mode      = 1'b0;
  int          held           = 0;
  int          quiet_cycles   = 0;
  int          items_sent     = 0;
  logic [15:0] ceiling_now    = DEFAULT_MAX_LEN;

  gnss_binary_frame_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  gfp_frame_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: long hold-off at the start of a hold phase, random stalls otherwise
  always @(posedge clk) begin
    if (hold_mode && held < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      held++;
    end else begin
      if (!hold_mode) held = 0;
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic req, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{req_type: req, in_byte: b};
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_frame(input logic [7:0] cls, input logic [7:0] mid,
                            input logic [15:0] len, input bit bad_ck,
                            input bit extra_sync, input int cut);
    logic [7:0] body[$];
    logic [7:0] sa;
    logic [7:0] sb;
    int         keep;
    body.insert(body.size(), cls);
    body.insert(body.size(), mid);
    body.insert(body.size(), len[7:0]);
    body.insert(body.size(), len[15:8]);
    // an oversize header is dropped by the parser, so nothing follows it
    if (len <= ceiling_now) begin
      repeat (len) body.insert(body.size(), 8'($urandom_range(255)));
      sa = '0;
      sb = '0;
      for (int i = 0; i < body.size(); i++) begin
        sa = sa + body[i];
        sb = sb + sa;
      end
      if (bad_ck) begin
        if ($urandom_range(1) == 0) sa = sa ^ (8'd1 << $urandom_range(7));
        else sb = sb ^ (8'd1 << $urandom_range(7));
      end
      body.insert(body.size(), sa);
      body.insert(body.size(), sb);
    end
    keep = (cut > 0 && cut < body.size()) ? cut : body.size();
    if (extra_sync) send_item(REQ_BYTE, SYNC_ONE);
    send_item(REQ_BYTE, SYNC_ONE);
    send_item(REQ_BYTE, SYNC_TWO);
    for (int i = 0; i < keep; i++) send_item(REQ_BYTE, body[i]);
    // a header cut short would read the next sync bytes as its length
    if (keep < 4) send_item(REQ_CLEAR, 8'($urandom_range(255)));
  endtask

  task automatic send_random_unit();
    int          roll;
    int          lim;
    logic [15:0] len;
    roll = $urandom_range(99);
    lim  = (ceiling_now < 12) ? ceiling_now : 12;
    if ($urandom_range(19) == 0)
      len = 16'($urandom_range((ceiling_now < 300) ? ceiling_now : 300));
    else
      len = 16'($urandom_range(lim));
    if (roll < 5) begin
      send_item(REQ_CLEAR, 8'($urandom_range(255)));
    end else if (roll < 14) begin
      repeat ($urandom_range(1, 4))
        send_item(REQ_BYTE, ($urandom_range(3) == 0) ? SYNC_ONE : 8'($urandom_range(255)));
    end else begin
      if (roll < 24 && ceiling_now != 16'hFFFF)
        len = 16'($urandom_range(65535, ceiling_now + 1));
      send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len,
                 ($urandom_range(99) < 15), ($urandom_range(9) == 0),
                 (roll >= 90) ? $urandom_range(1, len + 5) : 0);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_ceiling(input logic [15:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    ceiling_now = (v == 16'd0) ? 16'd1 : v;
  endtask

  task automatic run_phase(input logic [15:0] ceiling, input int idle_pct,
                           input int stall_pct, input bit hold);
    int start;
    write_ceiling(ceiling);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    hold_mode      = hold;
    start          = items_sent;
    while (items_sent - start < ITEMS_PER_PHASE) send_random_unit();
    hold_mode = 1'b0;
    wait_for_results();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: stray byte, repeated first sync, good one-byte frame,
    // empty frame with a bad checksum, oversize header, clear after a sync
    send_item(REQ_BYTE, 8'h00);
    send_frame(8'hFF, 8'h00, 16'd1, 1'b0, 1'b1, 0);
    send_frame(8'h00, 8'hFF, 16'd0, 1'b1, 1'b0, 0);
    send_frame(8'h01, 8'h02, 16'hFFFF, 1'b0, 1'b0, 0);
    send_item(REQ_BYTE, SYNC_ONE);
    send_item(REQ_CLEAR, 8'hFF);
    wait_for_results();

    run_phase(16'd4096, 0, 0, 1'b0);
    run_phase(16'd0, 71, 0, 1'b0);
    run_phase(16'hFFFF, 0, 71, 1'b0);
    run_phase(16'd8, 37, 37, 1'b1);
    run_phase(16'd1, 71, 0, 1'b0);
    run_phase(16'd300, 0, 71, 1'b0);
    run_phase(16'd24, 37, 37, 1'b0);

    if (fail_count == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
